>>> rtl/core/gdfs_pkg.sv
package gdfs_pkg;

   localparam int MAX_VERTICES_DEFAULT = 64;
   localparam int MAX_ARCS_DEFAULT     = 1024;
   localparam int VCOUNT_W             = 7;
   localparam int VERTEX_W             = 6;
   localparam int MODE_W               = 2;
   localparam int QUEUE_DEPTH          = 2;

   typedef enum logic [1:0] {
      MODE_CLEAR  = 2'd0,
      MODE_INSERT = 2'd1,
      MODE_SEARCH = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   // Classified command handed from front to back
   typedef struct packed {
      mode_type               op;
      logic [VERTEX_W-1:0]    src;
      logic [VERTEX_W-1:0]    dst;
   } cmd_type;

endpackage

>>> rtl/core/gdfs_ram.sv
module gdfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/gdfs_front.sv
module gdfs_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [15:0]             req_tdata,
   output logic                    cmd_valid,
   input  logic                    cmd_ready,
   output gdfs_pkg::cmd_type       cmd
);

   localparam int QD = gdfs_pkg::QUEUE_DEPTH;
   localparam int QW = $clog2(QD);

   gdfs_pkg::cmd_type   queue_ff [QD];
   logic [QW-1:0]       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QW:0]         fill_ff, fill_in;
   gdfs_pkg::cmd_type   incoming;
   logic                push, pop;

   // Classify the beat; drop unused mode at the door
   always_comb begin
      incoming.op  = gdfs_pkg::mode_type'(req_tdata[1:0]);
      incoming.src = req_tdata[7:2];
      incoming.dst = req_tdata[13:8];
   end

   assign req_tready = (fill_ff != (QW+1)'(QD));
   assign push       = req_tvalid && req_tready && (incoming.op != gdfs_pkg::MODE_NONE);
   assign cmd_valid  = (fill_ff != '0);
   assign pop        = cmd_valid && cmd_ready;
   assign cmd        = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? QW'((32'(wr_ptr_ff) + 1) % QD) : wr_ptr_ff;
      rd_ptr_in = pop  ? QW'((32'(rd_ptr_ff) + 1) % QD) : rd_ptr_ff;
      fill_in   = fill_ff + (QW+1)'(push) - (QW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         queue_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule

>>> rtl/core/gdfs_back.sv
module gdfs_back #(
   parameter int MAX_VERTICES = 64,
   parameter int MAX_ARCS     = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [gdfs_pkg::VCOUNT_W-1:0]      vertex_count,
   input  logic                               cmd_valid,
   output logic                               cmd_ready,
   input  gdfs_pkg::cmd_type                  cmd,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [15:0]                        rsp_tdata,
   output logic                               rsp_tlast
);

   localparam int VW = $clog2(MAX_VERTICES);
   localparam int AW = $clog2(MAX_ARCS);
   localparam int PW = AW + 1;
   localparam int SW = VW + 1;
   localparam int NW = gdfs_pkg::VCOUNT_W;

   typedef enum logic [3:0] {
      ST_IDLE, ST_INS_HEAD, ST_INS_LOAD, ST_INS_WAIT, ST_INS_CHK, ST_INS_WRITE,
      ST_SRCH_ROOT, ST_SRCH_EMIT, ST_SRCH_PUSH, ST_SRCH_TOP, ST_SRCH_ARC,
      ST_SRCH_CHK, ST_SRCH_POP
   } state_type;

   state_type            state_ff;
   logic [MAX_VERTICES-1:0] head_vld_ff, visited_ff;
   logic [PW-1:0]        used_ff, ptr_ff;
   logic [VW-1:0]        src_ff, dst_ff, root_ff, cur_ff;
   logic [PW-1:0]        top_cur_ff;
   logic [SW-1:0]        depth_ff;
   logic [SW-1:0]        disc_ff;
   logic                 root_done_ff;
   logic [NW-1:0]        live;
   logic                 out_vld_ff, out_last_ff;
   logic [VW-1:0]        out_vtx_ff, out_num_ff;
   logic [VW-1:0]        pend_vtx_ff;
   logic                 pend_ff;
   logic                 out_free;
   logic                 emit_go, search_end, out_load_last, out_load;

   // Arc memories
   logic                 arc_we;
   logic [AW-1:0]        arc_waddr, arc_raddr;
   logic [VW-1:0]        tgt_rd;
   logic [PW-1:0]        link_rd;
   logic [PW-1:0]        head_src, head_cur;

   // List head memory and frame stack memory
   logic                 head_we;
   logic [VW-1:0]        head_raddr;
   logic [PW-1:0]        head_rd;
   logic                 stk_we;
   logic [VW-1:0]        stk_waddr, stk_raddr;
   logic [PW-1:0]        stk_rd;

   assign live = (vertex_count > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : vertex_count;
   assign head_src  = head_vld_ff[src_ff] ? head_rd : PW'(MAX_ARCS);
   assign head_cur  = head_vld_ff[cur_ff] ? head_rd : PW'(MAX_ARCS);
   assign arc_we    = (state_ff == ST_INS_WRITE);
   assign arc_waddr = used_ff[AW-1:0];
   assign arc_raddr = ptr_ff[AW-1:0];

   // Head reads follow the discovered vertex during a push, else the source
   assign head_we    = (state_ff == ST_INS_WRITE);
   assign head_raddr = (state_ff == ST_SRCH_EMIT || state_ff == ST_SRCH_PUSH) ?
                       cur_ff : src_ff;

   // Output register and discovery handshake
   assign out_free      = !out_vld_ff || rsp_tready;
   assign emit_go       = (state_ff == ST_SRCH_EMIT) && (out_free || !pend_ff);
   assign search_end    = (state_ff == ST_SRCH_ROOT) &&
                          (root_done_ff || NW'(root_ff) >= live);
   assign out_load_last = search_end && pend_ff && out_free;
   assign out_load      = (emit_go && pend_ff) || out_load_last;

   // Spill the parent cursor on a push; read the frame below ahead of a pop
   assign stk_we    = emit_go && (depth_ff != '0);
   assign stk_waddr = depth_ff[VW-1:0] - VW'(1);
   assign stk_raddr = depth_ff[VW-1:0] - VW'(2);

   gdfs_ram #(.WIDTH(VW), .DEPTH(MAX_ARCS)) u_target (
      .clock(clock), .wr_en(arc_we), .wr_addr(arc_waddr), .wr_data(dst_ff),
      .rd_addr(arc_raddr), .rd_data(tgt_rd));
   gdfs_ram #(.WIDTH(PW), .DEPTH(MAX_ARCS)) u_link (
      .clock(clock), .wr_en(arc_we), .wr_addr(arc_waddr), .wr_data(head_src),
      .rd_addr(arc_raddr), .rd_data(link_rd));
   gdfs_ram #(.WIDTH(PW), .DEPTH(MAX_VERTICES)) u_head (
      .clock(clock), .wr_en(head_we), .wr_addr(src_ff), .wr_data(used_ff),
      .rd_addr(head_raddr), .rd_data(head_rd));
   gdfs_ram #(.WIDTH(PW), .DEPTH(MAX_VERTICES)) u_stack (
      .clock(clock), .wr_en(stk_we), .wr_addr(stk_waddr), .wr_data(top_cur_ff),
      .rd_addr(stk_raddr), .rd_data(stk_rd));

   assign cmd_ready  = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {4'b0, 6'(out_num_ff), 6'(out_vtx_ff)};

   // Sequencer for insert and search
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         head_vld_ff <= '0;
         visited_ff  <= '0;
         used_ff     <= '0;
         depth_ff    <= '0;
         disc_ff     <= '0;
         out_vld_ff  <= 1'b0;
         pend_ff     <= 1'b0;
      end else begin
         // Load the held discovery into the output, or drop a taken beat
         if (out_load) begin
            out_vld_ff  <= 1'b1;
            out_last_ff <= out_load_last;
            out_vtx_ff  <= pend_vtx_ff;
            out_num_ff  <= VW'(disc_ff - 1'b1);
         end else if (rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (cmd_valid) begin
                  src_ff <= cmd.src[VW-1:0];
                  dst_ff <= cmd.dst[VW-1:0];
                  case (cmd.op)
                     gdfs_pkg::MODE_CLEAR: begin
                        head_vld_ff <= '0;
                        used_ff     <= '0;
                     end
                     gdfs_pkg::MODE_INSERT: begin
                        if (NW'(cmd.src) < live && NW'(cmd.dst) < live &&
                            (MAX_VERTICES == 64 || (cmd.src >> VW) == 0) &&
                            (MAX_VERTICES == 64 || (cmd.dst >> VW) == 0)) begin
                           state_ff <= ST_INS_HEAD;
                        end
                     end
                     gdfs_pkg::MODE_SEARCH: begin
                        visited_ff   <= '0;
                        disc_ff      <= '0;
                        depth_ff     <= '0;
                        root_ff      <= '0;
                        root_done_ff <= 1'b0;
                        pend_ff      <= 1'b0;
                        state_ff     <= ST_SRCH_ROOT;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            // Wait for the source list head to be read
            ST_INS_HEAD: begin
               state_ff <= ST_INS_LOAD;
            end
            ST_INS_LOAD: begin
               ptr_ff   <= head_src;
               state_ff <= ST_INS_WAIT;
            end
            // Walk source list looking for a duplicate; drop the arc if the arc memory is full
            ST_INS_WAIT: begin
               if (ptr_ff < used_ff) begin
                  state_ff <= ST_INS_CHK;
               end else if (used_ff >= PW'(MAX_ARCS)) begin
                  state_ff <= ST_IDLE;
               end else begin
                  state_ff <= ST_INS_WRITE;
               end
            end
            ST_INS_CHK: begin
               if (tgt_rd == dst_ff) begin
                  state_ff <= ST_IDLE;
               end else begin
                  ptr_ff   <= link_rd;
                  state_ff <= ST_INS_WAIT;
               end
            end
            ST_INS_WRITE: begin
               head_vld_ff[src_ff] <= 1'b1;
               used_ff             <= used_ff + 1'b1;
               state_ff            <= ST_IDLE;
            end
            // Pick the next unvisited root, or finish
            ST_SRCH_ROOT: begin
               if (search_end) begin
                  if (out_load_last) begin
                     pend_ff  <= 1'b0;
                     state_ff <= ST_IDLE;
                  end else if (!pend_ff) begin
                     state_ff <= ST_IDLE;
                  end
               end else if (visited_ff[root_ff]) begin
                  if (root_ff == VW'(MAX_VERTICES - 1)) root_done_ff <= 1'b1;
                  else root_ff <= root_ff + 1'b1;
               end else begin
                  cur_ff   <= root_ff;
                  state_ff <= ST_SRCH_EMIT;
               end
            end
            // Discover cur_ff: flush the held result, hold this one, push
            ST_SRCH_EMIT: begin
               if (emit_go) begin
                  pend_ff            <= 1'b1;
                  pend_vtx_ff        <= cur_ff;
                  visited_ff[cur_ff] <= 1'b1;
                  disc_ff            <= disc_ff + 1'b1;
                  depth_ff           <= depth_ff + 1'b1;
                  state_ff           <= ST_SRCH_PUSH;
               end
            end
            // New frame starts at the head of its list
            ST_SRCH_PUSH: begin
               top_cur_ff <= head_cur;
               state_ff   <= ST_SRCH_TOP;
            end
            // Follow the top frame's cursor, or pop it
            ST_SRCH_TOP: begin
               if (top_cur_ff < used_ff) begin
                  ptr_ff   <= top_cur_ff;
                  state_ff <= ST_SRCH_ARC;
               end else begin
                  depth_ff <= depth_ff - 1'b1;
                  state_ff <= ST_SRCH_POP;
               end
            end
            // Restore the cursor of the frame below
            ST_SRCH_POP: begin
               if (depth_ff == '0) begin
                  state_ff <= ST_SRCH_ROOT;
               end else begin
                  top_cur_ff <= stk_rd;
                  state_ff   <= ST_SRCH_TOP;
               end
            end
            ST_SRCH_ARC: begin
               state_ff <= ST_SRCH_CHK;
            end
            ST_SRCH_CHK: begin
               top_cur_ff <= link_rd;
               if (NW'(tgt_rd) < live && !visited_ff[tgt_rd]) begin
                  cur_ff   <= tgt_rd;
                  state_ff <= ST_SRCH_EMIT;
               end else begin
                  state_ff <= ST_SRCH_TOP;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

>>> rtl/core/graph_dfs_preorder.sv
// Directed graph store with depth-first preorder numbering. Each req beat
// carries mode (0 clear, 1 insert arc from_vertex->to_vertex, 2 search);
// mode 3 is dropped. A search emits one rsp beat per discovered vertex with
// its preorder number, tlast on the final beat. Insert scans the source
// list for a duplicate before it writes the arc; a search steps through
// each root candidate, discovered vertex, examined arc and stack pop in
// turn, paced by the registered single read port of each memory, and stalls
// while the result register is held by rsp_tready. One command runs at a
// time; a two-entry queue takes further beats meanwhile.
module graph_dfs_preorder #(
   parameter int MAX_VERTICES = gdfs_pkg::MAX_VERTICES_DEFAULT,
   parameter int MAX_ARCS     = gdfs_pkg::MAX_ARCS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // mode[1:0], from_vertex[7:2], to_vertex[13:8]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // found_vertex[5:0], order_number[11:6]
   output logic        rsp_tlast
);

   logic [gdfs_pkg::VCOUNT_W-1:0] vcount_ff;
   logic                          cmd_valid, cmd_ready;
   gdfs_pkg::cmd_type             cmd;

   // Hold the vertex count register
   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= 7'd64;
      end else if (csr_wr_en) begin
         vcount_ff <= csr_wr_data;
      end
   end

   gdfs_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .cmd_valid, .cmd_ready, .cmd);

   gdfs_back #(.MAX_VERTICES(MAX_VERTICES), .MAX_ARCS(MAX_ARCS)) u_back (
      .clock, .reset, .vertex_count(vcount_ff), .cmd_valid, .cmd_ready, .cmd,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast);

   // Result beat must hold while stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat dropped under stall");

   // Last marker must hold while stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tlast))
      else $error("rsp tlast changed under stall");

   // Padding bits above the order number stay zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:12] == 4'b0)
      else $error("rsp padding set");

endmodule

>>> bench/graph_dfs_preorder_test.sv
module graph_dfs_preorder_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NV = 64;
   localparam int NA = 1024;
   localparam int SETTLE = 1500;
   localparam longint CYCLE_LIMIT = 3000000;

   typedef struct {
      logic [5:0] vertex;
      logic [5:0] order;
      logic       last;
   } discovery_type;

   typedef enum {ROW_CFG, ROW_ITEM} row_kind_type;

   typedef struct {
      row_kind_type       kind;
      gdfs_pkg::mode_type mode;
      int                 src;
      int                 dst;
      bit                 typed;   // expectation written below, not predicted
      int                 nres;
      int                 exp_v;
   } row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_wr_en = 0;
   logic [6:0]  csr_wr_data = '0;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;

   // graph mirror
   int            head [NV];
   int            arc_to [NA];
   int            arc_next [NA];
   int            arcs_held;
   int            vcount;
   discovery_type discovery_q [$];

   int          errors = 0;
   int          snd_idle = 0;
   int          rcv_idle = 0;
   int          hold_off = 0;
   longint      cycles = 0;

   graph_dfs_preorder u_top (.*);

   always #5 clock = ~clock;

   task automatic report(input string msg);
      errors++;
      $display("mismatch: %s", msg);
   endtask

   function automatic int live_count();
      return (vcount > NV) ? NV : vcount;
   endfunction

   // Advance the mirror by one command and queue the discoveries it yields
   function automatic void walk_graph(input gdfs_pkg::mode_type mode, input int src,
                                      input int dst, input bit keep);
      int n, p, w, sp, found, k;
      int seen [NV];
      int stk_v [NV];
      int stk_p [NV];
      discovery_type d;
      discovery_type got [$];
      bit pushed;
      n = live_count();
      case (mode)
         gdfs_pkg::MODE_CLEAR: begin
            foreach (head[i]) head[i] = NA;
            arcs_held = 0;
         end
         gdfs_pkg::MODE_INSERT: begin
            if (src < n && dst < n) begin
               p = head[src];
               found = 0;
               while (p < arcs_held) begin
                  if (arc_to[p] == dst) found = 1;
                  p = arc_next[p];
               end
               if (!found && arcs_held < NA) begin
                  arc_to[arcs_held] = dst;
                  arc_next[arcs_held] = head[src];
                  head[src] = arcs_held;
                  arcs_held++;
               end
            end
         end
         gdfs_pkg::MODE_SEARCH: begin
            foreach (seen[i]) seen[i] = 0;
            k = 0;
            for (int r = 0; r < n; r++) begin
               if (seen[r]) continue;
               seen[r] = 1;
               d.vertex = r; d.order = k; d.last = 0; got.push_back(d); k++;
               sp = 1; stk_v[0] = r; stk_p[0] = head[r];
               while (sp > 0) begin
                  pushed = 0;
                  while (stk_p[sp-1] < arcs_held) begin
                     w = arc_to[stk_p[sp-1]];
                     stk_p[sp-1] = arc_next[stk_p[sp-1]];
                     if (w < n && !seen[w]) begin
                        seen[w] = 1;
                        d.vertex = w; d.order = k; d.last = 0; got.push_back(d); k++;
                        stk_v[sp] = w; stk_p[sp] = head[w]; sp++;
                        pushed = 1;
                        break;
                     end
                  end
                  if (!pushed) sp--;
               end
            end
            if (got.size() > 0) got[got.size()-1].last = 1;
            if (keep) foreach (got[i]) discovery_q.push_back(got[i]);
         end
         default: ;
      endcase
   endfunction

   // Offer one beat, hold it until taken, then update the mirror
   task automatic send_beat(input gdfs_pkg::mode_type mode, input int src, input int dst,
                            input bit keep);
      int gap;
      req_tvalid <= 1;
      req_tdata  <= {2'b00, dst[5:0], src[5:0], mode};
      do @(posedge clock); while (!req_tready);
      walk_graph(mode, src, dst, keep);
      gap = 0;
      while ($urandom_range(99) < snd_idle) gap++;
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid, drain every discovery and let a trailing command finish
   task automatic wait_idle();
      req_tvalid <= 0;
      @(posedge clock);
      while (discovery_q.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_count(input int v);
      wait_idle();
      csr_wr_en   <= 1;
      csr_wr_data <= v[6:0];
      @(posedge clock);
      csr_wr_en <= 0;
      vcount = v;
   endtask

   // Receiver: random stalls, or a long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (hold_off > 0) begin
         hold_off   <= hold_off - 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rcv_idle);
      end
   end

   // Check each accepted result beat against the oldest discovery
   always @(posedge clock) begin
      discovery_type d;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (discovery_q.size() == 0) begin
            report($sformatf("unexpected beat vertex %0d", rsp_tdata[5:0]));
         end else begin
            d = discovery_q.pop_front();
            if (rsp_tdata[5:0] !== d.vertex)
               report($sformatf("vertex %0d, want %0d", rsp_tdata[5:0], d.vertex));
            if (rsp_tdata[11:6] !== d.order)
               report($sformatf("order %0d, want %0d", rsp_tdata[11:6], d.order));
            if (rsp_tlast !== d.last)
               report($sformatf("tlast %b, want %b", rsp_tlast, d.last));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      row_type rows [$];
      row_type r;
      discovery_type d;
      int n, pick, m, s, t;
      int counts [6] = '{64, 1, 2, 8, 127, 0};

      foreach (head[i]) head[i] = NA;
      arcs_held = 0;
      vcount = 64;

      // directed table
      rows = '{
         '{ROW_ITEM, gdfs_pkg::MODE_SEARCH, 0, 0, 0, 0, 0},  // empty graph, all roots
         '{ROW_CFG, gdfs_pkg::MODE_NONE, 1, 0, 0, 0, 0},
         '{ROW_ITEM, gdfs_pkg::MODE_SEARCH, 0, 0, 1, 1, 0},
         '{ROW_ITEM, gdfs_pkg::MODE_INSERT, 0, 0, 0, 0, 0},  // self loop
         '{ROW_ITEM, gdfs_pkg::MODE_INSERT, 0, 1, 0, 0, 0},  // endpoint out of range
         '{ROW_ITEM, gdfs_pkg::MODE_SEARCH, 0, 0, 1, 1, 0},
         '{ROW_CFG, gdfs_pkg::MODE_NONE, 0, 0, 0, 0, 0},     // no vertex in use
         '{ROW_ITEM, gdfs_pkg::MODE_INSERT, 0, 0, 0, 0, 0},
         '{ROW_ITEM, gdfs_pkg::MODE_SEARCH, 0, 0, 1, 0, 0},
         '{ROW_CFG, gdfs_pkg::MODE_NONE, 64, 0, 0, 0, 0},
         '{ROW_ITEM, gdfs_pkg::MODE_CLEAR, 0, 0, 0, 0, 0},
         '{ROW_ITEM, gdfs_pkg::MODE_INSERT, 63, 63, 0, 0, 0},
         '{ROW_ITEM, gdfs_pkg::MODE_INSERT, 0, 63, 0, 0, 0},
         '{ROW_ITEM, gdfs_pkg::MODE_INSERT, 0, 5, 0, 0, 0},
         '{ROW_ITEM, gdfs_pkg::MODE_INSERT, 0, 63, 0, 0, 0}, // duplicate
         '{ROW_ITEM, gdfs_pkg::MODE_INSERT, 5, 0, 0, 0, 0},
         '{ROW_ITEM, gdfs_pkg::MODE_INSERT, 63, 0, 0, 0, 0},
         '{ROW_ITEM, gdfs_pkg::MODE_NONE, 63, 63, 0, 0, 0},  // unused mode
         '{ROW_ITEM, gdfs_pkg::MODE_SEARCH, 0, 0, 0, 0, 0},
         '{ROW_CFG, gdfs_pkg::MODE_NONE, 4, 0, 0, 0, 0},     // count lowered after inserts
         '{ROW_ITEM, gdfs_pkg::MODE_SEARCH, 0, 0, 0, 0, 0},
         '{ROW_CFG, gdfs_pkg::MODE_NONE, 127, 0, 0, 0, 0},   // above maximum
         '{ROW_ITEM, gdfs_pkg::MODE_SEARCH, 0, 0, 0, 0, 0}
      };

      repeat (3) @(posedge clock);
      reset <= 0;

      snd_idle = 35;
      rcv_idle = 52;
      foreach (rows[i]) begin
         r = rows[i];
         if (r.kind == ROW_CFG) begin
            set_count(r.src);
         end else begin
            if (r.typed && r.nres == 1) begin
               d.vertex = r.exp_v; d.order = 0; d.last = 1;
               discovery_q.push_back(d);
            end
            send_beat(r.mode, r.src, r.dst, !r.typed);
         end
      end

      // dense graph on a few vertices with repeated arcs, then search it
      set_count(64);
      snd_idle = 0;
      rcv_idle = 0;
      send_beat(gdfs_pkg::MODE_CLEAR, 0, 0, 1);
      for (int i = 0; i < 48; i++)
         send_beat(gdfs_pkg::MODE_INSERT, i % 16, (i * 7 + 3) % 16, 1);
      send_beat(gdfs_pkg::MODE_SEARCH, 0, 0, 1);

      // random phases
      for (int ph = 0; ph < 6; ph++) begin
         set_count((ph == 5) ? $urandom_range(0, 127) : counts[ph]);
         snd_idle = (ph < 2) ? 35 : (ph < 4) ? 52 : 0;
         rcv_idle = (ph < 2) ? 52 : (ph < 4) ? 35 : 0;
         n = live_count();
         if (ph == 0) begin
            // long receiver stall while the sender keeps going
            send_beat(gdfs_pkg::MODE_CLEAR, 0, 0, 1);
            for (int i = 0; i < 12; i++) send_beat(gdfs_pkg::MODE_INSERT, i, i + 1, 1);
            hold_off = 3000;
            for (int i = 0; i < 4; i++) send_beat(gdfs_pkg::MODE_SEARCH, 0, 0, 1);
         end
         for (int i = 0; i < 35; i++) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
               m = gdfs_pkg::MODE_CLEAR;
            end else if (pick < 14) begin
               m = gdfs_pkg::MODE_SEARCH;
            end else if (pick < 17) begin
               m = gdfs_pkg::MODE_NONE;
            end else begin
               m = gdfs_pkg::MODE_INSERT;
            end
            if ($urandom_range(9) == 0 || n == 0) begin
               s = $urandom_range(63);
               t = $urandom_range(63);
            end else begin
               s = $urandom_range(n - 1);
               t = $urandom_range(n - 1);
            end
            send_beat(gdfs_pkg::mode_type'(m), s, t, 1);
         end
         send_beat(gdfs_pkg::MODE_SEARCH, 0, 0, 1);
      end

      wait_idle();
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
